// ===== design/multi_channel_tick_timer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-channel tick timer
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TICK_TIMER_TOP_MACROS_SVH
`define MULTI_CHANNEL_TICK_TIMER_TOP_MACROS_SVH

// Same-cycle implication.
`define MCTT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCTT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mctt_pkg.sv =====
// ----------------------------------------------------------------------------
// mctt_pkg
// Function codes, register indexes and shared types of the tick timer.
// ----------------------------------------------------------------------------
package mctt_pkg;

    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 16;
    localparam int SWMASK_W   = 8;
    localparam int WIDE_CNT_W = 32;
    localparam int WIDE_PRT_W = 16;
    localparam int REQ_W      = 3;

    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [REQ_W-1:0]     req_t;

    localparam func_t FN_TICK           = 3'd0;
    localparam func_t FN_SCROLL_START   = 3'd1;
    localparam func_t FN_SCROLL_STOP    = 3'd2;
    localparam func_t FN_DEBOUNCE_START = 3'd3;
    localparam func_t FN_DEBOUNCE_STOP  = 3'd4;
    localparam func_t FN_BEEP_START     = 3'd5;
    localparam func_t FN_BEEP_STOP      = 3'd6;

    localparam cfg_idx_t REG_DEBOUNCE_DELAY = 2'd0;
    localparam cfg_idx_t REG_SWITCH_MASK    = 2'd1;

    localparam logic [DELAY_W-1:0]  DEBOUNCE_DELAY_RST = 16'd2;
    localparam logic [SWMASK_W-1:0] SWITCH_MASK_RST    = 8'd3;

    localparam int REQ_SCROLL_BIT   = 0;
    localparam int REQ_DEBOUNCE_BIT = 1;
    localparam int REQ_BEEP_BIT     = 2;
    localparam req_t REQ_NONE       = 3'b000;

    typedef struct packed {
        logic scroll_expired;
        logic switch_changed;
        logic rearm_switch_irq;
        logic beep_done;
        logic wake;
        logic tick_enable;
    } result_flags_t;

endpackage

// ===== design/mctt_in_reg.sv =====
// ----------------------------------------------------------------------------
// mctt_in_reg
// Input register of the timer: captures one request and holds it until the
// result stage has room.
// ----------------------------------------------------------------------------
module mctt_in_reg #(
    parameter int COUNT_WIDTH = 16,
    parameter int PORT_WIDTH  = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid_i,
    output logic                     in_ready_o,
    input  mctt_pkg::func_t          func_i,
    input  logic [COUNT_WIDTH-1:0]   length_i,
    input  logic [PORT_WIDTH-1:0]    port_in_i,
    input  logic                     out_space_i,
    output logic                     advance_o,
    output mctt_pkg::func_t          func_o,
    output logic [COUNT_WIDTH-1:0]   length_o,
    output logic [PORT_WIDTH-1:0]    port_in_o
);
    import mctt_pkg::*;

    logic                   valid_reg;
    func_t                  func_reg;
    logic [COUNT_WIDTH-1:0] length_reg;
    logic [PORT_WIDTH-1:0]  port_reg;

    assign advance_o  = valid_reg && out_space_i;
    assign in_ready_o = !valid_reg || advance_o;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready_o) begin
            valid_reg <= in_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready_o && in_valid_i) begin
            func_reg   <= func_i;
            length_reg <= length_i;
            port_reg   <= port_in_i;
        end
    end

    assign func_o    = func_reg;
    assign length_o  = length_reg;
    assign port_in_o = port_reg;

endmodule

// ===== design/mctt_core.sv =====
// ----------------------------------------------------------------------------
// mctt_core
// Timer state, configuration registers and the per-request update logic.
// ----------------------------------------------------------------------------
`include "multi_channel_tick_timer_top_macros.svh"

module mctt_core #(
    parameter int COUNT_WIDTH = 16,
    parameter int PORT_WIDTH  = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid_i,
    input  mctt_pkg::cfg_idx_t          cfg_index_i,
    input  logic [mctt_pkg::CFG_DATA_W-1:0] cfg_data_i,
    input  logic                        step_i,
    input  mctt_pkg::func_t             func_i,
    input  logic [COUNT_WIDTH-1:0]      length_i,
    input  logic [PORT_WIDTH-1:0]       port_in_i,
    output mctt_pkg::result_flags_t     flags_o,
    output logic [PORT_WIDTH-1:0]       switch_levels_o
);
    import mctt_pkg::*;

    logic [DELAY_W-1:0]     delay_reg;
    logic [SWMASK_W-1:0]    swmask_reg;
    logic [COUNT_WIDTH-1:0] scroll_count_reg, scroll_count_next;
    logic [COUNT_WIDTH-1:0] scroll_period_reg, scroll_period_next;
    logic [COUNT_WIDTH-1:0] debounce_count_reg, debounce_count_next;
    logic [COUNT_WIDTH-1:0] beep_count_reg, beep_count_next;
    req_t                   req_reg, req_next;
    logic [PORT_WIDTH-1:0]  switch_state_reg, switch_state_next;

    logic [WIDE_CNT_W-1:0]  delay_wide;
    logic [WIDE_PRT_W-1:0]  swmask_wide;
    logic [COUNT_WIDTH-1:0] delay_load;
    logic [PORT_WIDTH-1:0]  swmask;
    logic                   tick;
    logic                   scroll_hit;
    logic                   debounce_hit;
    logic                   beep_hit;
    logic                   port_differs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg  <= DEBOUNCE_DELAY_RST;
            swmask_reg <= SWITCH_MASK_RST;
        end else if (cfg_valid_i) begin
            case (cfg_index_i)
                REG_DEBOUNCE_DELAY: delay_reg  <= cfg_data_i[DELAY_W-1:0];
                REG_SWITCH_MASK:    swmask_reg <= cfg_data_i[SWMASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign delay_wide  = WIDE_CNT_W'(delay_reg);
    assign delay_load  = delay_wide[COUNT_WIDTH-1:0];
    assign swmask_wide = WIDE_PRT_W'(swmask_reg);
    assign swmask      = swmask_wide[PORT_WIDTH-1:0];

    // A tick only counts while some timer keeps the time base running.
    assign tick         = (func_i == FN_TICK) && (req_reg != REQ_NONE);
    assign scroll_hit   = tick && (scroll_count_reg == COUNT_WIDTH'(1));
    assign debounce_hit = tick && (debounce_count_reg == COUNT_WIDTH'(1));
    assign beep_hit     = tick && (beep_count_reg == COUNT_WIDTH'(1));
    assign port_differs = ((switch_state_reg ^ port_in_i) & swmask) != '0;

    always_comb begin
        scroll_count_next   = scroll_count_reg;
        scroll_period_next  = scroll_period_reg;
        debounce_count_next = debounce_count_reg;
        beep_count_next     = beep_count_reg;
        req_next            = req_reg;
        switch_state_next   = switch_state_reg;
        case (func_i)
            FN_TICK: begin
                if (tick) begin
                    if (scroll_hit) begin
                        scroll_count_next = scroll_period_reg;
                    end else if (scroll_count_reg != '0) begin
                        scroll_count_next = scroll_count_reg - COUNT_WIDTH'(1);
                    end
                    if (debounce_count_reg != '0) begin
                        debounce_count_next = debounce_count_reg - COUNT_WIDTH'(1);
                    end
                    if (debounce_hit) begin
                        req_next[REQ_DEBOUNCE_BIT] = 1'b0;
                        if (port_differs) begin
                            switch_state_next = port_in_i;
                        end
                    end
                    if (beep_count_reg != '0) begin
                        beep_count_next = beep_count_reg - COUNT_WIDTH'(1);
                    end
                    if (beep_hit) begin
                        req_next[REQ_BEEP_BIT] = 1'b0;
                    end
                end
            end
            FN_SCROLL_START: begin
                scroll_count_next          = length_i;
                scroll_period_next         = length_i;
                req_next[REQ_SCROLL_BIT]   = 1'b1;
            end
            FN_SCROLL_STOP: begin
                scroll_count_next          = '0;
                req_next[REQ_SCROLL_BIT]   = 1'b0;
            end
            FN_DEBOUNCE_START: begin
                debounce_count_next        = delay_load;
                req_next[REQ_DEBOUNCE_BIT] = 1'b1;
            end
            FN_DEBOUNCE_STOP: begin
                debounce_count_next        = '0;
                req_next[REQ_DEBOUNCE_BIT] = 1'b0;
            end
            FN_BEEP_START: begin
                beep_count_next            = length_i;
                req_next[REQ_BEEP_BIT]     = 1'b1;
            end
            FN_BEEP_STOP: begin
                beep_count_next            = '0;
                req_next[REQ_BEEP_BIT]     = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scroll_count_reg   <= '0;
            scroll_period_reg  <= '0;
            debounce_count_reg <= '0;
            beep_count_reg     <= '0;
            req_reg            <= REQ_NONE;
            switch_state_reg   <= '0;
        end else if (step_i) begin
            scroll_count_reg   <= scroll_count_next;
            scroll_period_reg  <= scroll_period_next;
            debounce_count_reg <= debounce_count_next;
            beep_count_reg     <= beep_count_next;
            req_reg            <= req_next;
            switch_state_reg   <= switch_state_next;
        end
    end

    always_comb begin
        flags_o.scroll_expired   = scroll_hit;
        flags_o.switch_changed   = debounce_hit && port_differs;
        flags_o.rearm_switch_irq = debounce_hit && !port_differs;
        flags_o.beep_done        = beep_hit;
        flags_o.wake             = scroll_hit || (debounce_hit && port_differs);
        flags_o.tick_enable      = req_next != REQ_NONE;
    end

    assign switch_levels_o = switch_state_next;

    `MCTT_ASSERT_NXT(a_idle_tick_holds, step_i && (func_i == FN_TICK) && (req_reg == REQ_NONE), $stable(scroll_count_reg) && $stable(debounce_count_reg) && $stable(beep_count_reg), "tick while idle changed a counter")
    `MCTT_ASSERT_NXT(a_debounce_release, step_i && debounce_hit, !req_reg[REQ_DEBOUNCE_BIT], "debounce expiry left its request bit set")
    `MCTT_ASSERT_NXT(a_switch_hold, !(step_i && flags_o.switch_changed), $stable(switch_state_reg), "switch state moved without a reported change")

endmodule

// ===== design/mctt_out_reg.sv =====
// ----------------------------------------------------------------------------
// mctt_out_reg
// Result register: holds one packed result until the consumer takes it.
// ----------------------------------------------------------------------------
module mctt_out_reg #(
    parameter int PORT_WIDTH = 8,
    parameter int DATA_W     = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load_i,
    input  mctt_pkg::result_flags_t flags_i,
    input  logic [PORT_WIDTH-1:0]   switch_levels_i,
    output logic                    space_o,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_W-1:0]       m_tdata
);
    import mctt_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;

    assign space_o = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (space_o) begin
            valid_reg <= load_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (space_o && load_i) begin
            data_reg <= DATA_W'({flags_i.tick_enable, flags_i.wake, flags_i.beep_done,
                                 switch_levels_i, flags_i.rearm_switch_irq,
                                 flags_i.switch_changed, flags_i.scroll_expired});
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== design/multi_channel_tick_timer_top.sv =====
// ----------------------------------------------------------------------------
// multi_channel_tick_timer_top
// Three tick-driven down-counters (periodic scroll, one-shot debounce,
// one-shot beep) on a shared time base, with a streaming request/result
// interface and a small configuration write port.
//
//   Channel | Direction | Handshake           | Contents
//   --------+-----------+---------------------+-------------------------------
//   s_      | in        | s_tvalid / s_tready | s_tuser func, s_tdata length,
//           |           |                     | port_in
//   m_      | out       | m_tvalid / m_tready | m_tdata flags and switch levels
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A request is held in the input register and then moves into the result
// register, which drives m_tvalid and m_tdata until the result handshake.
// One request per cycle is sustained while m_tready stays high.
// Reset is synchronous on aresetn low: counters, request mask and switch
// state clear, and debounce_delay and switch_mask return to 2 and 3.
// A stall on m_tready backs up through the result register into the input
// register; s_tready falls only when both hold an unread request.
// ----------------------------------------------------------------------------
module multi_channel_tick_timer_top #(
    parameter int COUNT_WIDTH = 16,
    parameter int PORT_WIDTH  = 8
) (
    input  logic aclk,
    input  logic aresetn,

    // Request channel.
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata, low bit up: length [COUNT_WIDTH], port_in [PORT_WIDTH], zero fill.
    input  logic [((COUNT_WIDTH+PORT_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser: func [3].
    input  mctt_pkg::func_t s_tuser,

    // Result channel.
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata, low bit up: scroll_expired, switch_changed, rearm_switch_irq,
    // switch_levels [PORT_WIDTH], beep_done, wake, tick_enable, zero fill.
    output logic [((PORT_WIDTH+6+7)/8)*8-1:0] m_tdata,

    // Configuration writes: index 0 debounce_delay, index 1 switch_mask.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  mctt_pkg::cfg_idx_t              cfg_index,
    input  logic [mctt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mctt_pkg::*;

    localparam int M_DATA_W = ((PORT_WIDTH + 6 + 7) / 8) * 8;

    logic                   out_space;
    logic                   advance;
    func_t                  item_func;
    logic [COUNT_WIDTH-1:0] item_length;
    logic [PORT_WIDTH-1:0]  item_port;
    result_flags_t          flags;
    logic [PORT_WIDTH-1:0]  switch_levels;

    // Always writable; writes are issued only while idle by the user, unchecked.
    assign cfg_ready = 1'b1;

    mctt_in_reg #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .PORT_WIDTH  (PORT_WIDTH)
    ) u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid_i  (s_tvalid),
        .in_ready_o  (s_tready),
        .func_i      (s_tuser),
        .length_i    (s_tdata[COUNT_WIDTH-1:0]),
        .port_in_i   (s_tdata[COUNT_WIDTH+PORT_WIDTH-1:COUNT_WIDTH]),
        .out_space_i (out_space),
        .advance_o   (advance),
        .func_o      (item_func),
        .length_o    (item_length),
        .port_in_o   (item_port)
    );

    // The timer state moves exactly when a request passes into the result
    // register, so results keep request order.
    mctt_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .PORT_WIDTH  (PORT_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid_i     (cfg_valid && cfg_ready),
        .cfg_index_i     (cfg_index),
        .cfg_data_i      (cfg_data),
        .step_i          (advance),
        .func_i          (item_func),
        .length_i        (item_length),
        .port_in_i       (item_port),
        .flags_o         (flags),
        .switch_levels_o (switch_levels)
    );

    mctt_out_reg #(
        .PORT_WIDTH (PORT_WIDTH),
        .DATA_W     (M_DATA_W)
    ) u_out_reg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load_i          (advance),
        .flags_i         (flags),
        .switch_levels_i (switch_levels),
        .space_o         (out_space),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule
